@@ rtl/core/uart_panel_frame_receiver_assert.svh @@
// Assertion macros used by the panel frame receiver checker.
`ifndef UART_PANEL_FRAME_RECEIVER_ASSERT_SVH
`define UART_PANEL_FRAME_RECEIVER_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define UPFR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("upfr assertion failed");

// Consequent in the cycle after the antecedent.
`define UPFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("upfr assertion failed");

`endif

@@ rtl/core/upfr_pkg.sv @@
// Types and constants of the panel frame receiver.
package upfr_pkg;

	localparam logic [7:0] HEAD_PLAIN   = 8'd3;
	localparam logic [7:0] HEAD_EVENT   = 8'd6;
	localparam logic [7:0] ADDR_LOW     = 8'd1;
	localparam logic [7:0] ADDR_HIGH    = 8'd3;
	localparam logic [7:0] ADDR_FACTORY = 8'd3;
	localparam logic [7:0] MASK_RESET   = 8'd128;

	localparam logic [2:0] POS_HEAD  = 3'd0;
	localparam logic [2:0] POS_ADDR  = 3'd1;
	localparam logic [2:0] POS_KEY   = 3'd2;
	localparam logic [2:0] POS_HALL  = 3'd3;
	localparam logic [2:0] POS_CHECK = 3'd4;

	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_SET   = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;
	localparam logic [1:0] ACT_SENS  = 2'd3;

	typedef struct packed {
		logic [2:0] pos;
		logic [7:0] sum;
	} upfr_ctrl_t;

	typedef struct packed {
		logic [7:0] addr;
		logic [7:0] key;
		logic [7:0] hall;
	} upfr_data_t;

	typedef struct packed {
		logic       frame_valid;
		logic       checksum_error;
		logic [7:0] key_value;
		logic       hall_bit;
		logic       key_event;
		logic [1:0] factory_action;
	} upfr_result_t;

endpackage

@@ rtl/core/upfr_decode.sv @@
// Next-state and result logic for one received byte.
module upfr_decode import upfr_pkg::*; (
	input  upfr_ctrl_t   ctrl,
	input  upfr_data_t   data,
	input  logic [7:0]   rx_byte,
	input  logic         factory_hold,
	input  logic [7:0]   mask,
	output upfr_ctrl_t   ctrl_next,
	output upfr_data_t   data_next,
	output upfr_result_t result
);

	upfr_ctrl_t advance;
	upfr_ctrl_t restart;

	assign advance.pos = ctrl.pos + 3'd1;
	assign advance.sum = ctrl.sum + rx_byte;
	assign restart     = '0;

	always_comb begin
		ctrl_next = restart;
		data_next = data;
		result    = '0;
		if (!factory_hold) begin
			unique case (ctrl.pos)
				POS_HEAD: begin
					if (rx_byte == HEAD_PLAIN || rx_byte == HEAD_EVENT) ctrl_next = advance;
				end
				POS_ADDR: begin
					if (rx_byte >= ADDR_LOW && rx_byte <= ADDR_HIGH) begin
						ctrl_next      = advance;
						data_next.addr = rx_byte;
					end
				end
				POS_KEY: begin
					ctrl_next     = advance;
					data_next.key = rx_byte;
				end
				POS_HALL: begin
					ctrl_next      = advance;
					data_next.hall = rx_byte;
				end
				POS_CHECK: begin
					if (rx_byte == ctrl.sum) begin
						result.frame_valid = 1'b1;
						result.key_value   = data.key;
						result.hall_bit    = data.hall[0];
						result.key_event   = (data.key != 8'd0);
						if (data.addr == ADDR_FACTORY) result.factory_action = ACT_SET;
						else if ((data.key & mask) != 8'd0) result.factory_action = ACT_SENS;
						else result.factory_action = ACT_CLEAR;
					end else begin
						result.checksum_error = 1'b1;
					end
				end
				default: ctrl_next = restart;
			endcase
		end
	end

endmodule

@@ rtl/core/uart_panel_frame_receiver.sv @@
// Top level of the panel frame receiver: byte input stage, frame decode, result register.
//
// Usage: each transaction on the rx channel (rx_valid/rx_ready) carries one UART
// byte and the factory_hold flag. Every byte yields exactly one transaction on the
// res channel (res_valid/res_ready). A good frame is head (3 or 6), address (1 to 3),
// key byte, hall byte and the 8-bit sum of those four; the result of its checksum
// byte carries frame_valid, key_value, hall_bit, key_event and factory_action.
// Any other byte gives a result that is all zero, except a wrong checksum, which
// sets checksum_error.
// A byte is taken into the input register at its accepting edge and its result is
// loaded into the result register when the input stage advances. Throughput: one
// byte per cycle while the res channel does not stall, set by the single decode step.
// A stalled receiver fills the result register and then the input register, so
// one more byte is taken after a result starts waiting; rx_ready then drops until
// res_ready returns. The user must write the sensitivity mask by mask_we/mask_wdata
// only while idle; the block itself does not enforce this. Reset empties both
// registers, returns the receiver to the head position and sets the mask to 128.
module uart_panel_frame_receiver import upfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       mask_we,
	input  logic [7:0] mask_wdata,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	input  logic       factory_hold,
	output logic       res_valid,
	input  logic       res_ready,
	output logic       frame_valid,
	output logic       checksum_error,
	output logic [7:0] key_value,
	output logic       hall_bit,
	output logic       key_event,
	output logic [1:0] factory_action
);

	logic [7:0]   sens_mask_q;
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         hold_s1;
	logic         valid_s2;
	upfr_result_t result_s2;
	upfr_ctrl_t   ctrl_q;
	upfr_data_t   data_q;
	upfr_ctrl_t   ctrl_next;
	upfr_data_t   data_next;
	upfr_result_t result;
	logic         adv_s1;

	assign adv_s1   = valid_s1 && (!valid_s2 || res_ready);
	assign rx_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_mask_q <= MASK_RESET;
		end else if (mask_we) begin
			sens_mask_q <= mask_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			ctrl_q   <= '0;
		end else begin
			if (rx_ready) valid_s1 <= rx_valid;
			if (!valid_s2 || res_ready) valid_s2 <= valid_s1;
			if (adv_s1) ctrl_q <= ctrl_next;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			byte_s1 <= rx_byte;
			hold_s1 <= factory_hold;
		end
		if (adv_s1) begin
			data_q    <= data_next;
			result_s2 <= result;
		end
	end

	upfr_decode u_decode (
		.ctrl         (ctrl_q),
		.data         (data_q),
		.rx_byte      (byte_s1),
		.factory_hold (hold_s1),
		.mask         (sens_mask_q),
		.ctrl_next    (ctrl_next),
		.data_next    (data_next),
		.result       (result)
	);

	assign res_valid      = valid_s2;
	assign frame_valid    = result_s2.frame_valid;
	assign checksum_error = result_s2.checksum_error;
	assign key_value      = result_s2.key_value;
	assign hall_bit       = result_s2.hall_bit;
	assign key_event      = result_s2.key_event;
	assign factory_action = result_s2.factory_action;

endmodule

@@ rtl/core/upfr_checker.sv @@
// Port-level checker for the panel frame receiver, bound to the top level.
`include "uart_panel_frame_receiver_assert.svh"

module upfr_checker import upfr_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       mask_we,
	input logic [7:0] mask_wdata,
	input logic       rx_valid,
	input logic       rx_ready,
	input logic [7:0] rx_byte,
	input logic       factory_hold,
	input logic       res_valid,
	input logic       res_ready,
	input logic       frame_valid,
	input logic       checksum_error,
	input logic [7:0] key_value,
	input logic       hall_bit,
	input logic       key_event,
	input logic [1:0] factory_action
);

	// A result is a good frame, a bad checksum, or neither; never both.
	`UPFR_ASSERT_NOW(a_exclusive, clk, arst_n, res_valid, !(frame_valid && checksum_error))

	// Anything but a good frame reports no frame contents.
	`UPFR_ASSERT_NOW(a_quiet, clk, arst_n, res_valid && !frame_valid,
		key_value == 8'd0 && !hall_bit && !key_event && factory_action == ACT_NONE)

	// A good frame always has an action and flags an event exactly for a nonzero key.
	`UPFR_ASSERT_NOW(a_good, clk, arst_n, res_valid && frame_valid,
		factory_action != ACT_NONE && key_event == (key_value != 8'd0))

	// A stalled result holds its contents.
	`UPFR_ASSERT_NEXT(a_hold, clk, arst_n, res_valid && !res_ready,
		res_valid && $stable(key_value) && $stable(factory_action) && $stable(frame_valid))

endmodule

bind uart_panel_frame_receiver upfr_checker u_upfr_checker (.*);

@@ dv/tb_uart_panel_frame_receiver.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the panel frame receiver: directed frames, random traffic, stalls.
module tb_uart_panel_frame_receiver;
	import upfr_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_STALL     = 200;
	localparam int DRAIN_CYCLES   = 6;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       mask_we = 1'b0;
	logic [7:0] mask_wdata = '0;
	logic       rx_valid = 1'b0;
	logic       rx_ready;
	logic [7:0] rx_byte = '0;
	logic       factory_hold = 1'b0;
	logic       res_valid;
	logic       res_ready = 1'b0;
	logic       frame_valid;
	logic       checksum_error;
	logic [7:0] key_value;
	logic       hall_bit;
	logic       key_event;
	logic [1:0] factory_action;

	// Frame decoder state as seen by the testbench.
	logic [2:0] frame_pos;
	logic [7:0] frame_sum;
	logic [7:0] frame_addr;
	logic [7:0] frame_key;
	logic [7:0] frame_hall;
	logic [7:0] sens_mask;

	upfr_result_t pending_results[$];

	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int long_stall_req = 0;
	int long_stall_done = 0;
	int stall_left = 0;
	int err_cnt = 0;
	int idle_cycles = 0;

	uart_panel_frame_receiver i_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic upfr_result_t decode_panel_byte(input logic [7:0] b, input logic hold);
		upfr_result_t r;
		logic restart;
		r = '0;
		restart = 1'b0;
		if (hold) begin
			restart = 1'b1;
		end else begin
			case (frame_pos)
				POS_HEAD: begin
					restart = !(b == HEAD_PLAIN || b == HEAD_EVENT);
				end
				POS_ADDR: begin
					restart = (b < ADDR_LOW || b > ADDR_HIGH);
					if (!restart)
						frame_addr = b;
				end
				POS_KEY: begin
					frame_key = b;
				end
				POS_HALL: begin
					frame_hall = b;
				end
				POS_CHECK: begin
					restart = 1'b1;
					if (b == frame_sum) begin
						r.frame_valid = 1'b1;
						r.key_value   = frame_key;
						r.hall_bit    = frame_hall[0];
						r.key_event   = (frame_key != 8'h00);
						if (frame_addr == ADDR_FACTORY)
							r.factory_action = ACT_SET;
						else if ((frame_key & sens_mask) != 8'h00)
							r.factory_action = ACT_SENS;
						else
							r.factory_action = ACT_CLEAR;
					end else begin
						r.checksum_error = 1'b1;
					end
				end
				default: begin
					restart = 1'b1;
				end
			endcase
		end
		if (restart) begin
			frame_pos = POS_HEAD;
			frame_sum = '0;
		end else begin
			frame_pos = frame_pos + 3'd1;
			frame_sum = frame_sum + b;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] exp_v, got_v);
		$display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, exp_v, got_v);
		err_cnt++;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic hold);
		if ($urandom_range(99) < snd_idle_pct) begin
			rx_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
		end
		rx_valid     <= 1'b1;
		rx_byte      <= b;
		factory_hold <= hold;
		do @(posedge clk); while (!rx_ready);
		pending_results.push_back(decode_panel_byte(b, hold));
	endtask

	task automatic send_frame(input logic [7:0] head, addr, key, hall, chk_flip);
		logic [7:0] chk;
		chk = (head + addr + key + hall) ^ chk_flip;
		send_byte(head, 1'b0);
		send_byte(addr, 1'b0);
		send_byte(key, 1'b0);
		send_byte(hall, 1'b0);
		send_byte(chk, 1'b0);
	endtask

	task automatic drain();
		rx_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mask(input logic [7:0] m);
		mask_we    <= 1'b1;
		mask_wdata <= m;
		@(posedge clk);
		mask_we   <= 1'b0;
		sens_mask = m;
		@(posedge clk);
	endtask

	task automatic test_directed();
		// Factory set (zero key), sens, clear, sums wrap; bad checksum; stray bytes.
		send_frame(HEAD_PLAIN, ADDR_FACTORY, 8'h00, 8'hFE, 8'h00);
		send_frame(HEAD_EVENT, ADDR_LOW, 8'hFF, 8'h01, 8'h00);
		send_frame(HEAD_PLAIN, 8'd2, 8'h7F, 8'hFF, 8'h00);
		send_frame(HEAD_EVENT, 8'd2, 8'h80, 8'h00, 8'h01);
		send_byte(8'hFF, 1'b0);
		send_byte(HEAD_PLAIN, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(HEAD_EVENT, 1'b0);
		send_byte(8'h04, 1'b0);
		// A hold on a matching checksum byte must swallow the frame silently.
		send_byte(HEAD_PLAIN, 1'b0);
		send_byte(ADDR_LOW, 1'b0);
		send_byte(8'h10, 1'b0);
		send_byte(8'h20, 1'b0);
		send_byte(8'h34, 1'b1);
		drain();
	endtask

	task automatic test_random_traffic(input int n_items, snd_pct, rcv_pct,
					   input logic [7:0] mask);
		int sent;
		int cut;
		logic [7:0] frame [5];
		write_mask(mask);
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 75) begin
				frame[0] = $urandom_range(1) ? HEAD_EVENT : HEAD_PLAIN;
				frame[1] = 8'($urandom_range(ADDR_HIGH, ADDR_LOW));
				frame[2] = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom);
				frame[3] = 8'($urandom);
				frame[4] = frame[0] + frame[1] + frame[2] + frame[3];
				if ($urandom_range(99) < 15)
					frame[4] = frame[4] ^ 8'($urandom_range(255, 1));
				// Some frames are broken off early; a few bytes carry the hold flag.
				cut = ($urandom_range(99) < 10) ? $urandom_range(4, 1) : 5;
				for (int i = 0; i < cut; i++)
					send_byte(frame[i], $urandom_range(99) < 3);
				sent += cut;
			end else begin
				send_byte(8'($urandom), $urandom_range(99) < 20);
				sent++;
			end
		end
		drain();
	endtask

	task automatic test_backpressure();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		long_stall_req++;
		repeat (6)
			send_frame(HEAD_EVENT, 8'($urandom_range(ADDR_HIGH, ADDR_LOW)),
				   8'($urandom), 8'($urandom), 8'h00);
		drain();
	endtask

	// Result checking.
	always @(posedge clk) begin : result_check
		upfr_result_t exp_r;
		if (res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 8'h00, 8'h00);
			end else begin
				exp_r = pending_results.pop_front();
				if (frame_valid !== exp_r.frame_valid)
					report_mismatch("frame_valid", 8'(exp_r.frame_valid),
							8'(frame_valid));
				if (checksum_error !== exp_r.checksum_error)
					report_mismatch("checksum_error", 8'(exp_r.checksum_error),
							8'(checksum_error));
				if (key_value !== exp_r.key_value)
					report_mismatch("key_value", exp_r.key_value, key_value);
				if (hall_bit !== exp_r.hall_bit)
					report_mismatch("hall_bit", 8'(exp_r.hall_bit), 8'(hall_bit));
				if (key_event !== exp_r.key_event)
					report_mismatch("key_event", 8'(exp_r.key_event), 8'(key_event));
				if (factory_action !== exp_r.factory_action)
					report_mismatch("factory_action", 8'(exp_r.factory_action),
							8'(factory_action));
			end
		end
	end

	// The receiver's ready pattern, including the long stall counted in cycles.
	always @(posedge clk) begin
		if (long_stall_done < long_stall_req) begin
			long_stall_done++;
			stall_left = LONG_STALL;
		end
		if (stall_left > 0) begin
			stall_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// A long run of cycles without any transaction means the block has hung.
	always @(posedge clk) begin
		if ((rx_valid && rx_ready) || (res_valid && res_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_uart_panel_frame_receiver: FAIL");
			$finish;
		end
	end

	initial begin
		frame_pos  = POS_HEAD;
		frame_sum  = '0;
		frame_addr = '0;
		frame_key  = '0;
		frame_hall = '0;
		sens_mask  = MASK_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_traffic(280, 15, 64, 8'h00);
		test_random_traffic(280, 64, 15, 8'hFF);
		test_backpressure();
		test_random_traffic(260, 0, 0, 8'($urandom));
		if (err_cnt == 0)
			$display("tb_uart_panel_frame_receiver: PASS");
		else
			$display("tb_uart_panel_frame_receiver: FAIL");
		$finish;
	end

endmodule

@@ uart_panel_frame_receiver.f @@
+incdir+rtl/core
rtl/core/upfr_pkg.sv
rtl/core/upfr_decode.sv
rtl/core/uart_panel_frame_receiver.sv
rtl/core/upfr_checker.sv
dv/tb_uart_panel_frame_receiver.sv
